// ----- src/quaternion_to_euler_defines.svh -----
// Assertion macros shared by the quaternion to Euler RTL
`ifndef QUATERNION_TO_EULER_DEFINES_SVH
`define QUATERNION_TO_EULER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define Q2E_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define Q2E_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/q2e_pkg.sv -----
// Shared types, constants and tables for the quaternion to Euler pipeline
`timescale 1ns / 1ps
`default_nettype none
package q2e_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TAB_LEN          = 24;
    localparam int VEC_W            = 34;   // CORDIC input vector width
    localparam int CW               = 37;   // CORDIC internal x/y width
    localparam int ANG_W            = 26;   // Q16 degree accumulator width
    localparam int THR_W            = 29;
    localparam int S_W              = 31;   // 2*test, regular case only
    localparam int REM_W            = 57;   // 1 - s^2 in Q56
    localparam int SQ_W             = 58;   // square root datapath width
    localparam int SQ_STEPS         = 29;   // one root bit per stage
    localparam int ROOT_W           = 29;

    localparam logic [THR_W-1:0] THR_RESET = 29'd134217594;

    localparam logic signed [ANG_W-1:0] DEG90 = 26'sd5898240;

    localparam logic [1:0] POLE_NONE  = 2'd0;
    localparam logic [1:0] POLE_NORTH = 2'd1;
    localparam logic [1:0] POLE_SOUTH = 2'd2;

    // atan(2^-i) in Q16 degrees
    localparam logic signed [ANG_W-1:0] ATAN_TAB [TAB_LEN] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
        26'sd234379,  26'sd117304,  26'sd58671,  26'sd29335,
        26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
        26'sd917,     26'sd458,     26'sd229,    26'sd115,
        26'sd57,      26'sd29,      26'sd14,     26'sd7,
        26'sd4,       26'sd2,       26'sd1,      26'sd0
    };

    // item fields carried alongside the square root
    typedef struct packed {
        logic [1:0]              pole;
        logic signed [VEC_W-1:0] yaw_y;
        logic signed [VEC_W-1:0] yaw_x;
        logic signed [VEC_W-1:0] pit_y;
        logic signed [VEC_W-1:0] pit_x;
        logic signed [S_W-1:0]   s;
    } q2e_side_t;

endpackage
`default_nettype wire

// ----- src/q2e_sqrt.sv -----
// Pipelined integer square root, one result bit per stage, with side data
`timescale 1ns / 1ps
`default_nettype none
module q2e_sqrt (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    input  wire logic [q2e_pkg::REM_W-1:0] in_value,
    input  wire q2e_pkg::q2e_side_t        in_side,
    output logic                           out_valid,
    output logic [q2e_pkg::ROOT_W-1:0]     out_root,
    output q2e_pkg::q2e_side_t             out_side
);
    import q2e_pkg::*;

    logic [SQ_W-1:0]   v_reg    [1:SQ_STEPS];
    logic [SQ_W-1:0]   res_reg  [1:SQ_STEPS];
    q2e_side_t         side_reg [1:SQ_STEPS];
    logic [SQ_STEPS:1] val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= '0;
        end
        else
        begin
            val_reg <= {val_reg[SQ_STEPS-1:1], in_valid};
        end
    end

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_stage
        localparam int SH = 2 * (SQ_STEPS - 1 - k);
        logic [SQ_W-1:0] v_cur;
        logic [SQ_W-1:0] res_cur;
        q2e_side_t       side_cur;
        logic [SQ_W-1:0] bit_c;
        logic [SQ_W-1:0] trial;

        if (k == 0)
        begin : g_first
            assign v_cur    = {{(SQ_W-REM_W){1'b0}}, in_value};
            assign res_cur  = '0;
            assign side_cur = in_side;
        end
        else
        begin : g_rest
            assign v_cur    = v_reg[k];
            assign res_cur  = res_reg[k];
            assign side_cur = side_reg[k];
        end

        assign bit_c = SQ_W'(1) << SH;
        assign trial = res_cur + bit_c;

        always_ff @(posedge clk)
        begin
            side_reg[k+1] <= side_cur;
            if (v_cur >= trial)
            begin
                v_reg[k+1]   <= v_cur - trial;
                res_reg[k+1] <= (res_cur >> 1) + bit_c;
            end
            else
            begin
                v_reg[k+1]   <= v_cur;
                res_reg[k+1] <= res_cur >> 1;
            end
        end
    end

    assign out_valid = val_reg[SQ_STEPS];
    assign out_root  = res_reg[SQ_STEPS][ROOT_W-1:0];
    assign out_side  = side_reg[SQ_STEPS];

endmodule
`default_nettype wire

// ----- src/q2e_cordic.sv -----
// Pipelined vectoring CORDIC giving atan2(y, x) in Q16 degrees
`timescale 1ns / 1ps
`default_nettype none
module q2e_cordic #(
    parameter int STEPS = q2e_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    input  wire logic signed [q2e_pkg::VEC_W-1:0] in_y,
    input  wire logic signed [q2e_pkg::VEC_W-1:0] in_x,
    output logic                                  out_valid,
    output logic signed [q2e_pkg::ANG_W-1:0]      out_angle
);
    import q2e_pkg::*;

    localparam int NST = (STEPS < TAB_LEN) ? STEPS : TAB_LEN;

    logic signed [CW-1:0]    x_reg [NST+1];
    logic signed [CW-1:0]    y_reg [NST+1];
    logic signed [ANG_W-1:0] z_reg [NST+1];
    logic [NST:0]            zero_reg;
    logic [NST:0]            val_reg;

    logic signed [CW-1:0]    x_e, y_e, x_next, y_next;
    logic signed [ANG_W-1:0] z_next;

    // turn vectors in the left half plane toward positive x
    always_comb
    begin
        x_e = CW'(in_x);
        y_e = CW'(in_y);
        if (in_x[VEC_W-1])
        begin
            if (!in_y[VEC_W-1])
            begin
                x_next = y_e;
                y_next = -x_e;
                z_next = DEG90;
            end
            else
            begin
                x_next = -y_e;
                y_next = x_e;
                z_next = -DEG90;
            end
        end
        else
        begin
            x_next = x_e;
            y_next = y_e;
            z_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= '0;
        end
        else
        begin
            val_reg <= {val_reg[NST-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= x_next;
        y_reg[0]    <= y_next;
        z_reg[0]    <= z_next;
        zero_reg[0] <= (in_x == '0) && (in_y == '0);
    end

    for (genvar i = 0; i < NST; i++)
    begin : g_iter
        logic signed [CW-1:0] dx, dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            zero_reg[i+1] <= zero_reg[i];
            if (!y_reg[i][CW-1])
            begin
                x_reg[i+1] <= x_reg[i] + dx;
                y_reg[i+1] <= y_reg[i] - dy;
                z_reg[i+1] <= z_reg[i] + ATAN_TAB[i];
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] - dx;
                y_reg[i+1] <= y_reg[i] + dy;
                z_reg[i+1] <= z_reg[i] - ATAN_TAB[i];
            end
        end
    end

    assign out_valid = val_reg[NST];
    assign out_angle = zero_reg[NST] ? '0 : z_reg[NST];

endmodule
`default_nettype wire

// ----- src/quaternion_to_euler.sv -----
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// Depth is set by the 29-stage square root and the CORDIC stage chain.
// Reset clears the valid bits and loads thr_reg with 134217594.
// Top level: quaternion to yaw, roll and pitch in 1/64 degree
`timescale 1ns / 1ps
`default_nettype none
module quaternion_to_euler #(
    parameter int CORDIC_STEPS = q2e_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [q2e_pkg::THR_W-1:0]        cfg_wdata,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic signed [15:0]               quat_w,
    input  wire logic signed [15:0]               quat_x,
    input  wire logic signed [15:0]               quat_y,
    input  wire logic signed [15:0]               quat_z,
    output logic                                  done,
    output logic signed [15:0]                    yaw_deg,
    output logic signed [13:0]                    roll_deg,
    output logic signed [14:0]                    pitch_deg,
    output logic [1:0]                            pole_case
);
    import q2e_pkg::*;
    `include "quaternion_to_euler_defines.svh"

    localparam int CLAT = ((CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN) + 1;

    logic [THR_W-1:0] thr_reg;

    // stage 1: products
    logic v1_reg;
    logic signed [31:0] xy_reg, wz_reg, yw_reg, xz_reg, xw_reg, yz_reg;
    logic signed [31:0] xx_reg, yy_reg, zz_reg;
    logic signed [15:0] x1_reg, w1_reg;

    // stage 2: combine, classify
    logic v2_reg;
    q2e_side_t side2_reg;
    logic signed [32:0]      test_c;
    logic signed [VEC_W-1:0] yaw_y_c, yaw_x_c, pit_y_c, pit_x_c;
    logic [1:0]              pole_c;

    // stage 3: square, stage 4: remainder
    logic v3_reg, v4_reg;
    q2e_side_t side3_reg, side4_reg;
    logic signed [2*S_W-1:0] ssq_reg;
    logic [REM_W-1:0]        rem_reg;
    logic signed [2*S_W-1:0] one_q56;

    // square root output
    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    q2e_side_t         sq_side;

    // CORDIC outputs
    logic                    cy_valid, cr_valid, cp_valid;
    logic signed [ANG_W-1:0] yaw_ang, roll_ang, pit_ang;
    logic [1:0]              pole_dly_reg [CLAT];

    // final conversion
    logic signed [ANG_W:0]   yaw_z2;
    logic signed [16:0]      yaw_q, roll_q, pit_q;
    logic signed [17:0]      yaw_s;
    logic signed [15:0]      yaw_next;
    logic signed [13:0]      roll_next;
    logic signed [14:0]      pit_next;

    // terms for the checks
    logic is_north, is_south, north_ok, south_ok, yaw_ok;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            done    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            done   <= cy_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        xy_reg <= quat_x * quat_y;
        wz_reg <= quat_w * quat_z;
        yw_reg <= quat_y * quat_w;
        xz_reg <= quat_x * quat_z;
        xw_reg <= quat_x * quat_w;
        yz_reg <= quat_y * quat_z;
        xx_reg <= quat_x * quat_x;
        yy_reg <= quat_y * quat_y;
        zz_reg <= quat_z * quat_z;
        x1_reg <= quat_x;
        w1_reg <= quat_w;
    end

    always_comb
    begin
        test_c  = 33'(xy_reg) + 33'(wz_reg);
        yaw_y_c = (VEC_W'(yw_reg) - VEC_W'(xz_reg)) <<< 1;
        yaw_x_c = (VEC_W'(1) <<< 28) - ((VEC_W'(yy_reg) + VEC_W'(zz_reg)) <<< 1);
        pit_y_c = (VEC_W'(xw_reg) - VEC_W'(yz_reg)) <<< 1;
        pit_x_c = (VEC_W'(1) <<< 28) - ((VEC_W'(xx_reg) + VEC_W'(zz_reg)) <<< 1);
        priority if (test_c > $signed({4'b0, thr_reg}))
        begin
            pole_c = POLE_NORTH;
        end
        else if (test_c < -$signed({4'b0, thr_reg}))
        begin
            pole_c = POLE_SOUTH;
        end
        else
        begin
            pole_c = POLE_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        side2_reg.pole  <= pole_c;
        side2_reg.yaw_y <= (pole_c != POLE_NONE) ? VEC_W'(x1_reg) : yaw_y_c;
        side2_reg.yaw_x <= (pole_c != POLE_NONE) ? VEC_W'(w1_reg) : yaw_x_c;
        side2_reg.pit_y <= pit_y_c;
        side2_reg.pit_x <= pit_x_c;
        side2_reg.s     <= {test_c[S_W-2:0], 1'b0};
        side3_reg       <= side2_reg;
        ssq_reg         <= side2_reg.s * side2_reg.s;
        side4_reg       <= side3_reg;
        // clamp 1 - s^2 at zero
        rem_reg         <= (ssq_reg > one_q56) ? '0 : REM_W'(one_q56 - ssq_reg);
    end

    assign one_q56 = (2*S_W)'(1) <<< 56;

    q2e_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .in_value  (rem_reg),
        .in_side   (side4_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    q2e_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_y      (sq_side.yaw_y),
        .in_x      (sq_side.yaw_x),
        .out_valid (cy_valid),
        .out_angle (yaw_ang)
    );

    q2e_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_y      (VEC_W'(sq_side.s)),
        .in_x      ($signed({{(VEC_W-ROOT_W){1'b0}}, sq_root})),
        .out_valid (cr_valid),
        .out_angle (roll_ang)
    );

    q2e_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_y      (sq_side.pit_y),
        .in_x      (sq_side.pit_x),
        .out_valid (cp_valid),
        .out_angle (pit_ang)
    );

    // carry the pole code alongside the CORDIC stages
    always_ff @(posedge clk)
    begin
        pole_dly_reg[0] <= sq_side.pole;
        for (int i = 1; i < CLAT; i++)
        begin
            pole_dly_reg[i] <= pole_dly_reg[i-1];
        end
    end

    always_comb
    begin
        yaw_z2 = (pole_dly_reg[CLAT-1] != POLE_NONE) ? ((ANG_W+1)'(yaw_ang) <<< 1)
                                                     : (ANG_W+1)'(yaw_ang);
        yaw_q  = 17'((yaw_z2 + (ANG_W+1)'(512)) >>> 10);
        yaw_s  = (pole_dly_reg[CLAT-1] == POLE_SOUTH) ? -18'(yaw_q) : 18'(yaw_q);
        roll_q = 17'(((ANG_W+1)'(roll_ang) + (ANG_W+1)'(512)) >>> 10);
        pit_q  = 17'(((ANG_W+1)'(pit_ang) + (ANG_W+1)'(512)) >>> 10);

        priority if (yaw_s > 18'sd23040)
            yaw_next = 16'sd23040;
        else if (yaw_s < -18'sd23040)
            yaw_next = -16'sd23040;
        else
            yaw_next = 16'(yaw_s);

        unique case (pole_dly_reg[CLAT-1])
            POLE_NORTH:
            begin
                roll_next = 14'sd5760;
                pit_next  = '0;
            end
            POLE_SOUTH:
            begin
                roll_next = -14'sd5760;
                pit_next  = '0;
            end
            default:
            begin
                priority if (roll_q > 17'sd5760)
                    roll_next = 14'sd5760;
                else if (roll_q < -17'sd5760)
                    roll_next = -14'sd5760;
                else
                    roll_next = 14'(roll_q);
                priority if (pit_q > 17'sd11520)
                    pit_next = 15'sd11520;
                else if (pit_q < -17'sd11520)
                    pit_next = -15'sd11520;
                else
                    pit_next = 15'(pit_q);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        yaw_deg   <= yaw_next;
        roll_deg  <= roll_next;
        pitch_deg <= pit_next;
        pole_case <= pole_dly_reg[CLAT-1];
    end

    assign is_north = done && (pole_case == POLE_NORTH);
    assign is_south = done && (pole_case == POLE_SOUTH);
    assign north_ok = (roll_deg == 14'sd5760) && (pitch_deg == 15'sd0);
    assign south_ok = (roll_deg == -14'sd5760) && (pitch_deg == 15'sd0);
    assign yaw_ok   = (yaw_deg <= 16'sd23040) && (yaw_deg >= -16'sd23040);

    `Q2E_ASSERT_NEXT(a_start_enters, clk, rst_n, start && !busy, v1_reg, "item not taken")
    `Q2E_ASSERT_NOW(a_pole_code, clk, rst_n, done, pole_case != 2'd3, "bad pole code")
    `Q2E_ASSERT_NOW(a_north, clk, rst_n, is_north, north_ok, "north pole angles wrong")
    `Q2E_ASSERT_NOW(a_south, clk, rst_n, is_south, south_ok, "south pole angles wrong")
    `Q2E_ASSERT_NOW(a_yaw_range, clk, rst_n, done, yaw_ok, "yaw out of range")
    `Q2E_ASSERT_NOW(a_lanes, clk, rst_n, cy_valid, cr_valid && cp_valid, "CORDIC lanes out of step")

endmodule
`default_nettype wire
